// ----- sv/tpp_pkg.sv -----
// tpp_pkg: shared types, result codes and constants for the terminal padding parser
// no dependencies; imported by every module of the block
`default_nettype none

package tpp_pkg;

    localparam int MAX_DIGITS_DEF = 8;
    localparam int CFG_DATA_W     = 22;
    localparam int BAUD_W         = 22;

    // result kinds
    localparam logic [1:0] KIND_LIT  = 2'd0;
    localparam logic [1:0] KIND_PAD  = 2'd1;
    localparam logic [1:0] KIND_WAIT = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_USE_SLEEP   = 3'd0;
    localparam logic [2:0] CFG_XON_FLOW    = 3'd1;
    localparam logic [2:0] CFG_THR_PRESENT = 3'd2;
    localparam logic [2:0] CFG_THR_BAUD    = 3'd3;
    localparam logic [2:0] CFG_BAUD_RATE   = 3'd4;
    localparam logic [2:0] CFG_FILL_CHAR   = 3'd5;

    // ceil(2^36 / 125), exact floor(n / 125) for n below 2^29
    localparam logic [29:0] DIV125_MUL = 30'd549755814;

    typedef struct packed {
        logic [7:0]  ch;
        logic        end_of_string;
        logic        always_delay;
        logic [15:0] line_count;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_res;
        logic [31:0] amount;
        logic        final_res;
    } t_out_word;

    // one result on its way from the parser to the pad count pipeline
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_res;
        logic [31:0] value;
        logic        final_res;
    } t_item;

    typedef struct packed {
        logic       use_sleep;
        logic       normal;
        logic [7:0] fill_char;
    } t_parse_cfg;

    typedef struct packed {
        logic [12:0] baud_q;
        logic [9:0]  baud_r;
    } t_pad_cfg;

    // floor(v / 1000) as floor((v / 8) / 125) by reciprocal multiply
    function automatic logic [22:0] quot1000(input logic [31:0] v);
        logic [58:0] p;
        p = 59'(v[31:3]) * 59'(DIV125_MUL);
        return p[58:36];
    endfunction

endpackage

`default_nettype wire

// ----- sv/tpp_parser.sv -----
// tpp_parser: delay marker parser, pending character buffer and front result stage
// depends on tpp_pkg; feeds tpp_pad_pipe one result per cycle while it takes them
`default_nettype none

module tpp_parser #(
    parameter int MAX_DIGITS = tpp_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire tpp_pkg::t_in_word   i_word,
    input  wire tpp_pkg::t_parse_cfg i_cfg,
    output logic                     o_item_valid,
    output tpp_pkg::t_item           o_item,
    input  wire logic                i_item_take
);
    import tpp_pkg::*;

    localparam int BUF_DEPTH = MAX_DIGITS + 6;
    localparam int IDX_W     = $clog2(BUF_DEPTH);
    localparam int CNT_W     = $clog2(BUF_DEPTH + 2);
    localparam int DIG_W     = $clog2(MAX_DIGITS + 1);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_DOLLAR = 3'd1;
    localparam logic [2:0] PH_OPEN   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_DOT    = 3'd4;
    localparam logic [2:0] PH_TENTH  = 3'd5;
    localparam logic [2:0] PH_SUFFIX = 3'd6;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int SUF_STAR  = 0;
    localparam int SUF_SLASH = 1;

    // marker state
    logic [2:0]       r_phase,  n_phase;
    logic [CNT_W-1:0] r_pcount, n_pcount;
    logic [DIG_W-1:0] r_dcount, n_dcount;
    logic [31:0]      r_value,  n_value;
    logic [1:0]       r_suffix, n_suffix;
    logic             r_mand,   n_mand;
    logic [7:0]       r_pend [BUF_DEPTH];

    // front result stage
    logic             r_s1_v;
    logic             r_s1_mark;
    logic [1:0]       r_s1_kind;
    logic [31:0]      r_s1_value;
    logic [7:0]       r_s1_head;
    logic [7:0]       r_s1_tail;
    logic [CNT_W-1:0] r_s1_mid;
    logic [CNT_W-1:0] r_s1_last;
    logic [CNT_W-1:0] r_s1_pos;

    logic             accept;
    logic             s1_last;
    logic             is_dig;
    logic [3:0]       dval;
    logic [35:0]      t10;
    logic [35:0]      t10d;
    logic [32:0]      tten;
    logic [47:0]      tstar;
    logic [31:0]      v10;
    logic [31:0]      vdig;
    logic [31:0]      vten;
    logic [31:0]      vstar;
    logic             marker;
    logic             cont;
    logic             do_push;
    logic             tail_chk;
    logic             fin;
    logic             start;
    logic             eos_flush;
    logic             lits;
    logic             tail;
    logic             honor;
    logic [CNT_W-1:0] mid;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;

    // saturating value updates
    always_comb begin
        is_dig = (i_word.ch >= CH_ZERO) && (i_word.ch <= CH_NINE);
        dval   = i_word.ch[3:0];
        t10    = {1'b0, r_value, 3'b000} + {3'b000, r_value, 1'b0};
        t10d   = t10 + {32'd0, dval};
        tten   = {1'b0, r_value} + {29'd0, dval};
        tstar  = r_value * i_word.line_count;
        v10    = (|t10[35:32])    ? 32'hFFFF_FFFF : t10[31:0];
        vdig   = (|t10d[35:32])   ? 32'hFFFF_FFFF : t10d[31:0];
        vten   = tten[32]         ? 32'hFFFF_FFFF : tten[31:0];
        vstar  = (|tstar[47:32])  ? 32'hFFFF_FFFF : tstar[31:0];
    end

    // next marker state for the word on the input
    always_comb begin
        n_phase  = r_phase;
        n_pcount = r_pcount;
        n_dcount = r_dcount;
        n_value  = r_value;
        n_suffix = r_suffix;
        n_mand   = r_mand;
        cont     = 1'b0;
        do_push  = 1'b0;
        tail_chk = 1'b0;
        fin      = 1'b0;
        marker   = (r_phase != PH_IDLE) && (r_phase <= PH_SUFFIX);

        unique case (r_phase)
            PH_DOLLAR: begin
                if (i_word.ch == CH_LT) begin
                    cont    = 1'b1;
                    do_push = 1'b1;
                    n_phase = PH_OPEN;
                end
            end
            PH_OPEN, PH_DIGITS: begin
                if (is_dig) begin
                    if (r_dcount < DIG_W'(MAX_DIGITS)) begin
                        cont     = 1'b1;
                        do_push  = 1'b1;
                        n_dcount = r_dcount + 1'b1;
                        n_value  = vdig;
                        n_phase  = PH_DIGITS;
                    end
                end else if (r_phase == PH_DIGITS) begin
                    if (i_word.ch == CH_DOT) begin
                        cont    = 1'b1;
                        do_push = 1'b1;
                        n_value = v10;
                        n_phase = PH_DOT;
                    end else begin
                        tail_chk = 1'b1;
                    end
                end
            end
            PH_DOT: begin
                if (is_dig) begin
                    cont    = 1'b1;
                    do_push = 1'b1;
                    n_value = vten;
                    n_phase = PH_TENTH;
                end
            end
            PH_TENTH, PH_SUFFIX: begin
                tail_chk = 1'b1;
            end
            default: ;
        endcase

        if (tail_chk) begin
            priority if (i_word.ch == CH_GT) begin
                cont     = 1'b1;
                fin      = 1'b1;
                n_phase  = PH_IDLE;
                n_pcount = '0;
                n_mand   = r_mand | r_suffix[SUF_SLASH];
            end else if (i_word.ch == CH_STAR && !r_suffix[SUF_STAR]) begin
                cont               = 1'b1;
                do_push            = 1'b1;
                n_suffix[SUF_STAR] = 1'b1;
                n_value            = vstar;
                n_phase            = PH_SUFFIX;
            end else if (i_word.ch == CH_SLASH && !r_suffix[SUF_SLASH]) begin
                cont                = 1'b1;
                do_push             = 1'b1;
                n_suffix[SUF_SLASH] = 1'b1;
                n_phase             = PH_SUFFIX;
            end else begin
                cont = 1'b0;
            end
        end

        if (do_push && (r_pcount < CNT_W'(BUF_DEPTH))) begin
            n_pcount = r_pcount + 1'b1;
        end

        // character not taken by a marker: start a new one or pass it on
        start = (i_word.ch == CH_DOLLAR) && (!marker || !cont);
        if (!marker || !cont) begin
            if (start) begin
                n_phase  = PH_DOLLAR;
                n_pcount = CNT_W'(1);
                n_dcount = '0;
                n_value  = '0;
                n_suffix = '0;
            end else begin
                n_phase  = PH_IDLE;
                n_pcount = '0;
            end
        end

        eos_flush = i_word.end_of_string && (n_phase != PH_IDLE);
        if (i_word.end_of_string) begin
            n_phase  = PH_IDLE;
            n_pcount = '0;
            n_mand   = 1'b0;
        end

        lits  = marker ? (!cont || eos_flush) : (!start || eos_flush);
        tail  = marker && (cont ? eos_flush : (!start || eos_flush));
        mid   = marker ? CNT_W'(r_pcount - 1'b1) : '0;
        honor = fin && (r_value != 32'd0) &&
                (i_word.always_delay || i_cfg.normal || r_mand || r_suffix[SUF_SLASH]);

        wr_en  = accept && (start || (do_push && (r_pcount < CNT_W'(BUF_DEPTH))));
        wr_idx = start ? '0 : r_pcount[IDX_W-1:0];
    end

    assign s1_last = r_s1_mark || (r_s1_pos == r_s1_last);
    assign o_ready = !r_s1_v || (i_item_take && s1_last);
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_pcount <= '0;
            r_dcount <= '0;
            r_value  <= '0;
            r_suffix <= '0;
            r_mand   <= 1'b0;
            r_s1_v   <= 1'b0;
        end else begin
            if (accept) begin
                r_phase  <= n_phase;
                r_pcount <= n_pcount;
                r_dcount <= n_dcount;
                r_value  <= n_value;
                r_suffix <= n_suffix;
                r_mand   <= n_mand;
                r_s1_v   <= lits || honor;
            end else if (r_s1_v && i_item_take && s1_last) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pend[wr_idx] <= i_word.ch;
        end
        if (accept) begin
            r_s1_mark  <= !lits;
            r_s1_kind  <= i_cfg.use_sleep ? KIND_WAIT : KIND_PAD;
            r_s1_value <= r_value;
            r_s1_head  <= marker ? r_pend[0] : i_word.ch;
            r_s1_tail  <= i_word.ch;
            r_s1_mid   <= mid;
            r_s1_last  <= mid + CNT_W'(tail);
            r_s1_pos   <= '0;
        end else if (r_s1_v && i_item_take) begin
            r_s1_pos <= r_s1_pos + 1'b1;
        end
    end

    // current result of the front stage
    always_comb begin
        o_item = '0;
        if (r_s1_mark) begin
            o_item.kind      = r_s1_kind;
            o_item.byte_res  = (r_s1_kind == KIND_PAD) ? i_cfg.fill_char : 8'd0;
            o_item.value     = r_s1_value;
            o_item.final_res = 1'b1;
        end else begin
            o_item.kind      = KIND_LIT;
            o_item.value     = '0;
            o_item.final_res = (r_s1_pos == r_s1_last);
            priority if (r_s1_pos == '0) begin
                o_item.byte_res = r_s1_head;
            end else if (r_s1_pos <= r_s1_mid) begin
                o_item.byte_res = r_pend[r_s1_pos[IDX_W-1:0]];
            end else begin
                o_item.byte_res = r_s1_tail;
            end
        end
    end

    assign o_item_valid = r_s1_v;

endmodule

`default_nettype wire

// ----- sv/tpp_pad_pipe.sv -----
// tpp_pad_pipe: four stage pipeline that turns a delay value into a pad count
// depends on tpp_pkg; takes results from tpp_parser, drives the output word
`default_nettype none

module tpp_pad_pipe (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_item_valid,
    input  wire tpp_pkg::t_item    i_item,
    output logic                   o_take,
    input  wire tpp_pkg::t_pad_cfg i_cfg,
    output logic                   o_valid,
    output tpp_pkg::t_out_word     o_word,
    input  wire logic              i_ready
);
    import tpp_pkg::*;

    // count = v*q + a*r + floor(b*r / 1000), baud = 1000q + r, v = 1000a + b
    logic        r_x_v, r_y_v, r_z_v, r_o_v;
    t_item       r_x_item, r_y_item, r_z_item;
    logic [44:0] r_x_vq;
    logic [22:0] r_x_a;
    logic [9:0]  r_y_b;
    logic [45:0] r_y_sum, r_z_sum;
    logic [19:0] r_z_br;
    t_out_word   r_o_word;

    logic        ld_x, ld_y, ld_z, ld_o;
    logic [44:0] x_vq;
    logic [32:0] y_ak;
    logic [32:0] y_ar;
    logic [19:0] z_br;
    logic [22:0] o_q2;
    logic [45:0] o_tot;
    logic [31:0] o_cnt;
    logic        o_keep;
    t_out_word   n_o_word;

    assign ld_o   = !r_o_v || i_ready;
    assign ld_z   = !r_z_v || ld_o;
    assign ld_y   = !r_y_v || ld_z;
    assign ld_x   = !r_x_v || ld_y;
    assign o_take = ld_x;

    always_comb begin
        x_vq  = i_item.value * i_cfg.baud_q;
        y_ak  = r_x_a * 33'd1000;
        y_ar  = r_x_a * i_cfg.baud_r;
        z_br  = r_y_b * i_cfg.baud_r;
        o_q2  = quot1000(32'(r_z_br));
        o_tot = r_z_sum + 46'(o_q2);
        o_cnt = (|o_tot[45:32]) ? 32'hFFFF_FFFF : o_tot[31:0];

        o_keep             = !((r_z_item.kind == KIND_PAD) && (o_cnt == 32'd0));
        n_o_word.kind      = r_z_item.kind;
        n_o_word.byte_res  = r_z_item.byte_res;
        n_o_word.amount    = (r_z_item.kind == KIND_PAD) ? o_cnt : r_z_item.value;
        n_o_word.final_res = r_z_item.final_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v <= 1'b0;
            r_y_v <= 1'b0;
            r_z_v <= 1'b0;
            r_o_v <= 1'b0;
        end else begin
            if (ld_x) r_x_v <= i_item_valid;
            if (ld_y) r_y_v <= r_x_v;
            if (ld_z) r_z_v <= r_y_v;
            if (ld_o) r_o_v <= r_z_v && o_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_x) begin
            r_x_item <= i_item;
            r_x_vq   <= x_vq;
            r_x_a    <= quot1000(i_item.value);
        end
        if (ld_y) begin
            r_y_item <= r_x_item;
            r_y_b    <= 10'(r_x_item.value - y_ak[31:0]);
            r_y_sum  <= 46'(r_x_vq) + 46'(y_ar);
        end
        if (ld_z) begin
            r_z_item <= r_y_item;
            r_z_br   <= z_br;
            r_z_sum  <= r_y_sum;
        end
        if (ld_o) begin
            r_o_word <= n_o_word;
        end
    end

    assign o_valid = r_o_v;
    assign o_word  = r_o_word;

endmodule

`default_nettype wire

// ----- sv/terminal_padding_parser.sv -----
// terminal_padding_parser: top level, configuration registers and baud split
// depends on tpp_pkg, tpp_parser and tpp_pad_pipe
//
// Input channel (i_in_valid / o_in_ready / i_in_word) takes one character of an
// output string per word. Output channel (o_out_valid / i_out_ready /
// o_out_word) gives literal bytes, pad runs and wait requests in string order.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data), written
// while the block is idle (not enforced by the block); the baud quotient is
// registered from the baud rate, and the remainder then from both.
// A result passes the front result stage and stages x, y, z, o. Throughput:
// one input word per cycle when each word gives at most one result and the
// output does not stall. A word that flushes a broken marker gives up to
// MAX_DIGITS + 7 literal results; the front result stage sends one per cycle
// while taken and holds the input channel until the last of them is taken.
// The pad count pipeline (reciprocal divide by 1000 split over four stages) sets
// the latency; the front result stage sets the rate.
// Reset clears the marker state, the pipeline and all configuration registers.
// When the receiver stalls, words collect in the pipeline stages and input
// acceptance stops only once every stage is full.
`default_nettype none

module terminal_padding_parser #(
    parameter int MAX_DIGITS = tpp_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire tpp_pkg::t_in_word                 i_in_word,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output tpp_pkg::t_out_word                     o_out_word,
    input  wire logic                              i_cfg_we,
    input  wire logic [2:0]                        i_cfg_idx,
    input  wire logic [tpp_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import tpp_pkg::*;

    logic              r_use_sleep;
    logic              r_xon_flow;
    logic              r_thr_present;
    logic [BAUD_W-1:0] r_thr_baud;
    logic [BAUD_W-1:0] r_baud;
    logic [7:0]        r_fill;
    logic [12:0]       r_baud_q;
    logic [9:0]        r_baud_r;

    logic [22:0]       baud_quot;
    logic [22:0]       baud_qk;
    t_parse_cfg        parse_cfg;
    t_pad_cfg          pad_cfg;
    logic              item_valid;
    t_item             item;
    logic              item_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_sleep   <= 1'b0;
            r_xon_flow    <= 1'b0;
            r_thr_present <= 1'b0;
            r_thr_baud    <= '0;
            r_baud        <= '0;
            r_fill        <= '0;
            r_baud_q      <= '0;
            r_baud_r      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_USE_SLEEP:   r_use_sleep   <= i_cfg_data[0];
                    CFG_XON_FLOW:    r_xon_flow    <= i_cfg_data[0];
                    CFG_THR_PRESENT: r_thr_present <= i_cfg_data[0];
                    CFG_THR_BAUD:    r_thr_baud    <= i_cfg_data[BAUD_W-1:0];
                    CFG_BAUD_RATE:   r_baud        <= i_cfg_data[BAUD_W-1:0];
                    CFG_FILL_CHAR:   r_fill        <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            r_baud_q <= baud_quot[12:0];
            r_baud_r <= 10'(r_baud - baud_qk[BAUD_W-1:0]);
        end
    end

    always_comb begin
        baud_quot = quot1000(32'(r_baud));
        baud_qk   = r_baud_q * 23'd1000;

        parse_cfg.use_sleep = r_use_sleep;
        parse_cfg.fill_char = r_fill;
        parse_cfg.normal    = !r_xon_flow && r_thr_present && (r_baud != '0) &&
                              (r_baud >= r_thr_baud);

        pad_cfg.baud_q = r_baud_q;
        pad_cfg.baud_r = r_baud_r;
    end

    tpp_parser #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_word       (i_in_word),
        .i_cfg        (parse_cfg),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_take  (item_take)
    );

    tpp_pad_pipe u_pad_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_take       (item_take),
        .i_cfg        (pad_cfg),
        .o_valid      (o_out_valid),
        .o_word       (o_out_word),
        .i_ready      (i_out_ready)
    );

endmodule

`default_nettype wire

// ----- tb/tb_terminal_padding_parser.sv -----
// tb_terminal_padding_parser: self-checking bench for the terminal padding parser
// depends on tpp_pkg and terminal_padding_parser; a behavioral copy of the marker
// parser predicts every result word, checked in order under random idling and stalls

module tb_terminal_padding_parser;
    import tpp_pkg::*;

    localparam int DIGIT_LIMIT  = MAX_DIGITS_DEF;
    localparam int IDLE_PCT     = 17;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;

    localparam logic [7:0] CH_DOLLAR = "$";
    localparam logic [7:0] CH_OPEN   = "<";
    localparam logic [7:0] CH_CLOSE  = ">";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_NINE   = "9";

    typedef enum logic [2:0] {
        MK_IDLE, MK_DOLLAR, MK_OPEN, MK_DIGITS, MK_DOT, MK_TENTH, MK_SUFFIX
    } t_mark_phase;

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_in_word              in_word  = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_word             out_word;
    logic                  cfg_we   = 1'b0;
    logic [2:0]            cfg_idx  = CFG_USE_SLEEP;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers
    logic        mode_sleep = 1'b0;
    logic        mode_xon   = 1'b0;
    logic        thr_on     = 1'b0;
    logic [21:0] thr_baud   = '0;
    logic [21:0] line_baud  = '0;
    logic [7:0]  pad_fill   = '0;

    // predictor copy of the marker state
    logic [7:0]  marker_buf[$];
    t_mark_phase marker_phase  = MK_IDLE;
    int unsigned marker_digits = 0;
    logic [63:0] marker_value  = '0;
    logic        seen_star     = 1'b0;
    logic        seen_slash    = 1'b0;
    logic        mandatory_pad = 1'b0;

    t_out_word   step_words[$];
    t_out_word   due_words[$];
    logic [7:0]  text_q[$];

    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;
    logic        gaps_on      = 1'b1;
    logic        stalls_on    = 1'b1;
    logic        hold_request = 1'b0;

    terminal_padding_parser uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] clamp32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void add_result(input logic [1:0] kind, input logic [7:0] b,
                                       input logic [31:0] amt);
        t_out_word w;
        w.kind      = kind;
        w.byte_res  = b;
        w.amount    = amt;
        w.final_res = 1'b0;
        step_words.push_back(w);
    endfunction

    function automatic void flush_marker();
        foreach (marker_buf[i]) add_result(KIND_LIT, marker_buf[i], 32'd0);
        marker_buf.delete();
        marker_phase = MK_IDLE;
    endfunction

    function automatic void take_plain(input logic [7:0] c);
        if (c == CH_DOLLAR) begin
            marker_buf.delete();
            marker_digits = 0;
            marker_value  = '0;
            seen_star     = 1'b0;
            seen_slash    = 1'b0;
            marker_buf.push_back(c);
            marker_phase  = MK_DOLLAR;
        end else begin
            add_result(KIND_LIT, c, 32'd0);
        end
    endfunction

    function automatic void close_marker(input logic always_on);
        logic        normal;
        logic [63:0] cnt;
        marker_buf.delete();
        marker_phase = MK_IDLE;
        if (seen_slash) mandatory_pad = 1'b1;
        normal = !mode_xon && thr_on && line_baud != 0 && line_baud >= thr_baud;
        if (marker_value == 0 || !(always_on || normal || mandatory_pad)) return;
        if (mode_sleep) begin
            add_result(KIND_WAIT, 8'd0, marker_value[31:0]);
        end else begin
            cnt = clamp32((marker_value * 64'(line_baud)) / 64'd1000);
            if (cnt != 0) add_result(KIND_PAD, pad_fill, cnt[31:0]);
        end
    endfunction

    // returns 0 when the character breaks the marker
    function automatic logic extend_marker(input logic [7:0] c, input logic always_on,
                                           input logic [15:0] lines);
        case (marker_phase)
            MK_DOLLAR: begin
                if (c != CH_OPEN) return 1'b0;
                marker_buf.push_back(c);
                marker_phase = MK_OPEN;
                return 1'b1;
            end
            MK_OPEN, MK_DIGITS: begin
                if (is_decimal(c)) begin
                    if (marker_digits >= DIGIT_LIMIT) return 1'b0;
                    marker_buf.push_back(c);
                    marker_digits++;
                    marker_value = clamp32(marker_value * 64'd10 + 64'(c) - 64'(CH_ZERO));
                    marker_phase = MK_DIGITS;
                    return 1'b1;
                end
                if (marker_phase == MK_OPEN) return 1'b0;
                if (c == CH_DOT) begin
                    marker_buf.push_back(c);
                    marker_value = clamp32(marker_value * 64'd10);
                    marker_phase = MK_DOT;
                    return 1'b1;
                end
            end
            MK_DOT: begin
                if (!is_decimal(c)) return 1'b0;
                marker_buf.push_back(c);
                marker_value = clamp32(marker_value + 64'(c) - 64'(CH_ZERO));
                marker_phase = MK_TENTH;
                return 1'b1;
            end
            MK_TENTH, MK_SUFFIX: ;
            default: return 1'b0;
        endcase
        if (c == CH_CLOSE) begin
            close_marker(always_on);
            return 1'b1;
        end
        if (c == CH_STAR) begin
            if (seen_star) return 1'b0;
            seen_star = 1'b1;
            marker_buf.push_back(c);
            marker_value = clamp32(marker_value * 64'(lines));
            marker_phase = MK_SUFFIX;
            return 1'b1;
        end
        if (c == CH_SLASH) begin
            if (seen_slash) return 1'b0;
            seen_slash = 1'b1;
            marker_buf.push_back(c);
            marker_phase = MK_SUFFIX;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void predict_padding(input t_in_word w);
        t_out_word last_word;
        step_words.delete();
        if (marker_phase == MK_IDLE) begin
            take_plain(w.ch);
        end else if (!extend_marker(w.ch, w.always_delay, w.line_count)) begin
            flush_marker();
            take_plain(w.ch);
        end
        if (w.end_of_string) begin
            if (marker_phase != MK_IDLE) flush_marker();
            mandatory_pad = 1'b0;
        end
        if (step_words.size() > 0) begin
            last_word = step_words.pop_back();
            last_word.final_res = 1'b1;
            step_words.push_back(last_word);
        end
        foreach (step_words[i]) due_words.push_back(step_words[i]);
    endfunction

    task automatic log_mismatch(input string what, input t_out_word got, input t_out_word want);
        fail_count++;
        if (fail_count <= 50)
            $display("mismatch (%s): got kind %0d byte %02h amount %0d final %0b, %s",
                     what, got.kind, got.byte_res, got.amount, got.final_res,
                     $sformatf("exp kind %0d byte %02h amount %0d final %0b",
                               want.kind, want.byte_res, want.amount, want.final_res));
    endtask

    task automatic send_char(input t_in_word w);
        if (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        predict_padding(w);
    endtask

    task automatic send_str(input string s, input logic eos_last, input logic always_on,
                            input logic [15:0] lines);
        t_in_word w;
        int       i;
        for (i = 0; i < s.len(); i++) begin
            w.ch            = s[i];
            w.end_of_string = eos_last && (i == s.len() - 1);
            w.always_delay  = always_on;
            w.line_count    = lines;
            send_char(w);
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [21:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_USE_SLEEP:   mode_sleep = val[0];
            CFG_XON_FLOW:    mode_xon   = val[0];
            CFG_THR_PRESENT: thr_on     = val[0];
            CFG_THR_BAUD:    thr_baud   = val;
            CFG_BAUD_RATE:   line_baud  = val;
            CFG_FILL_CHAR:   pad_fill   = val[7:0];
            default: ;
        endcase
    endtask

    // baud goes first so its split settles before the next word
    task automatic setup_regs(input logic [21:0] d_sleep, input logic [21:0] d_xon,
                              input logic [21:0] d_thrp, input logic [21:0] d_thr,
                              input logic [21:0] d_baud, input logic [21:0] d_fill);
        wait_idle();
        write_reg(CFG_BAUD_RATE, d_baud);
        write_reg(CFG_THR_BAUD, d_thr);
        write_reg(CFG_THR_PRESENT, d_thrp);
        write_reg(CFG_XON_FLOW, d_xon);
        write_reg(CFG_USE_SLEEP, d_sleep);
        write_reg(CFG_FILL_CHAR, d_fill);
        cfg_we <= 1'b0;
    endtask

    // strings of markers with random content, plus literal runs and broken markers
    task automatic run_random_strings(input int unsigned n_items);
        int unsigned sent, parts, p, nd, i, r;
        t_in_word    w;
        sent = 0;
        while (sent < n_items) begin
            text_q.delete();
            parts = $urandom_range(1, 3);
            for (p = 0; p < parts; p++) begin
                if ($urandom_range(99) < 30) begin
                    repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
                end else begin
                    text_q.push_back(CH_DOLLAR);
                    if ($urandom_range(99) < 5) begin
                        text_q.push_back(8'($urandom_range(0, 255)));
                    end else begin
                        text_q.push_back(CH_OPEN);
                        r = $urandom_range(99);
                        if (r < 3) nd = 0;
                        else if (r < 60) nd = $urandom_range(1, 3);
                        else if (r < 88) nd = $urandom_range(4, DIGIT_LIMIT);
                        else nd = $urandom_range(DIGIT_LIMIT + 1, DIGIT_LIMIT + 2);
                        for (i = 0; i < nd; i++)
                            text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                        if ($urandom_range(99) < 30) begin
                            text_q.push_back(CH_DOT);
                            text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                            if ($urandom_range(99) < 10)
                                text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                        end
                        case ($urandom_range(0, 19))
                            0:       begin text_q.push_back(CH_STAR); text_q.push_back(CH_STAR); end
                            1:       begin text_q.push_back(CH_SLASH); text_q.push_back(CH_SLASH); end
                            2, 3, 4: text_q.push_back(CH_STAR);
                            5, 6, 7: text_q.push_back(CH_SLASH);
                            8, 9:    begin text_q.push_back(CH_STAR); text_q.push_back(CH_SLASH); end
                            10, 11:  begin text_q.push_back(CH_SLASH); text_q.push_back(CH_STAR); end
                            default: ;
                        endcase
                        r = $urandom_range(99);
                        if (r < 85) text_q.push_back(CH_CLOSE);
                        else if (r < 93) text_q.push_back(8'($urandom_range(0, 255)));
                    end
                end
            end
            for (i = 0; i < text_q.size(); i++) begin
                r = $urandom_range(99);
                w.ch            = text_q[i];
                w.end_of_string = (i == text_q.size() - 1);
                w.always_delay  = ($urandom_range(99) < 30);
                w.line_count    = (r < 10) ? 16'd0 :
                                  (r < 20) ? 16'hFFFF :
                                  (r < 50) ? 16'($urandom_range(1, 4)) : 16'($urandom);
                send_char(w);
            end
            sent += text_q.size();
        end
    endtask

    task automatic test_literal_extremes();
        send_char('{ch: 8'h00, end_of_string: 1'b0, always_delay: 1'b1, line_count: 16'hFFFF});
        send_char('{ch: 8'hFF, end_of_string: 1'b1, always_delay: 1'b0, line_count: 16'h0000});
    endtask

    task automatic test_marker_forms();
        setup_regs(22'd0, 22'd0, 22'd1, 22'd0, 22'd9600, 22'hFF);
        send_str("$<5.5*>", 1'b0, 1'b0, 16'hFFFF);
        send_str("$<1.23>", 1'b1, 1'b0, 16'd1);
        send_str("$$<2/>", 1'b0, 1'b0, 16'd0);
        send_str("$<", 1'b1, 1'b1, 16'd0);
    endtask

    task automatic test_wait_request();
        setup_regs(22'd1, 22'd1, 22'd0, 22'd0, 22'd0, 22'd0);
        send_str("$<7>", 1'b0, 1'b1, 16'd3);
        send_str("$<4/>", 1'b1, 1'b0, 16'd2);
    endtask

    task automatic test_fast_line_no_idle();
        setup_regs(22'd0, 22'd0, 22'd1, 22'd1200, 22'd4000000, 22'h00);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        run_random_strings(12);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_sleep_with_flow_control();
        setup_regs(22'd1, 22'd1, 22'd0, 22'd0, 22'd0, 22'h5A);
        run_random_strings(12);
    endtask

    task automatic test_width_extremes();
        setup_regs(22'd0, 22'd0, 22'd1, 22'd4000000, 22'd4000000, 22'hFF);
        run_random_strings(12);
    endtask

    task automatic test_unknown_baud();
        setup_regs(22'd0, 22'd0, 22'd1, 22'd4000000, 22'd0, 22'h20);
        run_random_strings(12);
    endtask

    // upper data bits are junk for the narrow registers
    task automatic test_random_registers();
        int unsigned round;
        for (round = 0; round < 3; round++) begin
            setup_regs(22'($urandom), 22'($urandom), 22'($urandom),
                       22'($urandom_range(0, 4000000)),
                       $urandom_range(1) ? 22'($urandom_range(0, 4000000)) : 22'd9600,
                       22'($urandom));
            run_random_strings(4);
        end
    endtask

    task automatic test_output_holdoff();
        hold_request = 1'b1;
        run_random_strings(30);
        wait_idle();
    endtask

    initial begin : ready_control
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= !(stalls_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (due_words.size() == 0) log_mismatch("unexpected word", out_word, '0);
            else begin
                if (out_word.kind != due_words[0].kind ||
                    out_word.byte_res != due_words[0].byte_res ||
                    out_word.amount != due_words[0].amount ||
                    out_word.final_res != due_words[0].final_res)
                    log_mismatch("field", out_word, due_words[0]);
                void'(due_words.pop_front());
            end
        end
        if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin : run
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_literal_extremes();
        test_marker_forms();
        test_wait_request();
        test_fast_line_no_idle();
        test_sleep_with_flow_control();
        test_width_extremes();
        test_unknown_baud();
        test_random_registers();
        test_output_holdoff();
        if (fail_count == 0 && due_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
